/* design/ipc_pkg.sv */
// shared types and constants of the planar to chunky converter
`default_nettype none
package ipc_pkg;

	localparam int PIX_W    = 8;
	localparam int WORD_W   = 16;
	localparam int GROUP_PIX = 16;
	localparam int IDX_W    = 4;
	localparam int MODE_W   = 3;
	localparam int RW_W     = 13;

	localparam logic [MODE_W-1:0] MODE_PLANE8 = 3'd3;
	localparam logic [MODE_W-1:0] MODE_RGB565 = 3'd4;

	localparam logic REG_PLANE_MODE = 1'b0;
	localparam logic REG_ROW_WIDTH  = 1'b1;

	localparam logic [IDX_W-1:0] LAST_IDX = 4'd15;

	typedef struct packed {
		logic                             rgb;
		logic [GROUP_PIX-1:0][PIX_W-1:0] pix;
		logic [PIX_W-1:0]                 red;
		logic [PIX_W-1:0]                 green;
		logic [PIX_W-1:0]                 blue;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage
`default_nettype wire

/* design/ipc_front.sv */
// front end: collects plane words and builds pixel groups
`default_nettype none
module ipc_front import ipc_pkg::*; #(
	parameter int MAX_PLANES = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [MODE_W-1:0] plane_mode,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [WORD_W-1:0] s_tdata,
	input  wire q_status_t         q_stat,
	output logic                   q_push,
	output job_t                   q_job
);

	localparam int PWD = (MAX_PLANES > 1) ? MAX_PLANES - 1 : 1;
	localparam int PCW = (PWD + 1 > 2) ? $clog2(PWD + 1) : 1;
	localparam int IW  = (PWD > 1) ? $clog2(PWD) : 1;
	localparam logic [3:0] MAXP = 4'(MAX_PLANES);

	logic [WORD_W-1:0] pw_q [PWD];
	logic [PCW-1:0]    pc_q;
	logic [3:0]        planes;
	logic              mode_ok;
	logic              is_rgb;
	logic              completes;
	logic              makes_job;
	logic              accept;
	logic [7:0][WORD_W-1:0] wsel;

	assign is_rgb   = (plane_mode == MODE_RGB565);
	assign planes   = 4'd1 << plane_mode[1:0];
	assign mode_ok  = (plane_mode <= MODE_PLANE8) && (planes <= MAXP);
	assign completes = mode_ok && !((4'(pc_q) + 4'd1) < planes);
	assign makes_job = is_rgb || completes;
	assign s_tready = !q_stat.full || !makes_job;
	assign accept   = s_tvalid && s_tready;
	assign q_push   = accept && makes_job;

	genvar k;
	for (k = 0; k < 8; k++) begin : g_plane
		if (k < MAX_PLANES - 1) begin : g_st
			assign wsel[k] = (4'(k + 1) < planes) ? pw_q[k] :
				((4'(k + 1) == planes) ? s_tdata : '0);
		end else if (k < MAX_PLANES) begin : g_lw
			assign wsel[k] = (4'(k + 1) == planes) ? s_tdata : '0;
		end else begin : g_zero
			assign wsel[k] = '0;
		end
	end

	always_comb begin
		q_job.rgb   = is_rgb;
		q_job.red   = {s_tdata[15:11], 3'b000};
		q_job.green = {s_tdata[10:5], 2'b00};
		q_job.blue  = {s_tdata[4:0], 3'b000};
		for (int i = 0; i < GROUP_PIX; i++) begin
			for (int b = 0; b < 8; b++) begin
				q_job.pix[i][b] = wsel[b][15-i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
		end else if (accept) begin
			if (is_rgb || completes) begin
				pc_q <= '0;
			end else if (mode_ok) begin
				pc_q <= pc_q + PCW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && mode_ok && !completes && !is_rgb) begin
			pw_q[pc_q[IW-1:0]] <= s_tdata;
		end
	end

endmodule
`default_nettype wire

/* design/ipc_queue.sv */
// two-entry queue of pixel groups between front and back
`default_nettype none
module ipc_queue import ipc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t push_job,
	input  wire logic pop,
	output job_t      head_job,
	output q_status_t stat
);

	job_t       mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign stat.full  = (cnt_q == 2'd2);
	assign stat.empty = (cnt_q == 2'd0);
	assign head_job   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_job;
	end

endmodule
`default_nettype wire

/* design/ipc_back.sv */
// back end: streams pixels of each group and tracks the row position
`default_nettype none
module ipc_back import ipc_pkg::*; #(
	parameter int MAX_WIDTH = 4096
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic [RW_W-1:0] row_width,
	input  wire job_t            head_job,
	input  wire q_status_t       q_stat,
	output logic                 q_pop,
	output logic                 m_tvalid,
	input  wire logic            m_tready,
	output logic [31:0]          m_tdata,
	output logic                 m_tuser,
	output logic                 m_tlast
);

	localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
	localparam int WW = (CW + 1 > 14) ? CW + 1 : 14;

	logic [IDX_W-1:0] idx_q;
	logic [CW-1:0]    col_q;
	logic             valid_q;
	logic [31:0]      data_q;
	logic             burst_q;
	logic             eor_q;
	logic [13:0]      rnd;
	logic [WW-1:0]    padded;
	logic             adv;
	logic             emit;
	logic             last;
	logic             eor;

	assign rnd    = ((14'(row_width) + 14'd15) >> 4) << 4;
	always_comb begin
		padded = (rnd == 14'd0) ? WW'(16) : WW'(rnd);
		if (padded > WW'(MAX_WIDTH)) padded = WW'(MAX_WIDTH);
	end

	assign adv   = !valid_q || m_tready;
	assign emit  = adv && !q_stat.empty;
	assign last  = head_job.rgb || (idx_q == LAST_IDX);
	assign q_pop = emit && last;
	assign eor   = (WW'(col_q) + WW'(1)) >= padded;

	assign m_tvalid = valid_q;
	assign m_tdata  = data_q;
	assign m_tuser  = burst_q;
	assign m_tlast  = eor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
			col_q   <= '0;
		end else if (adv) begin
			valid_q <= !q_stat.empty;
			if (emit) begin
				idx_q <= last ? '0 : idx_q + IDX_W'(1);
				col_q <= eor ? '0 : col_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (head_job.rgb) begin
				data_q <= {head_job.blue, head_job.green, head_job.red, 8'd0};
			end else begin
				data_q <= {24'd0, head_job.pix[idx_q]};
			end
			burst_q <= last;
			eor_q   <= eor;
		end
	end

	a_mid_group_held: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != '0 |-> !q_stat.empty)
		else $error("group left the queue before its last pixel");

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		WW'(col_q) < WW'(MAX_WIDTH))
		else $error("column position beyond maximum width");

	a_row_restart: assert property (@(posedge clk) disable iff (!arst_n)
		emit && eor |=> col_q == '0)
		else $error("column not restarted after end of row");

	a_rgb_single: assert property (@(posedge clk) disable iff (!arst_n)
		emit && head_job.rgb |-> idx_q == '0)
		else $error("rgb word entered mid group");

endmodule
`default_nettype wire

/* design/interleaved_planar_to_chunky_unit.sv */
// top level of the interleaved bitplane to chunky pixel converter
// a group-completing word is written into the group queue; its first pixel is then
//   loaded into the back end output register; the back end emits one pixel per cycle
//   while not stalled and a group is queued (16 per planar group, one per 16-bit word)
// the rate is set by the back end pixel sequencer and the two-entry group queue
// reset is asynchronous: counters, queue and output valid clear, mode 0, width 320,
//   stored plane words keep their contents until written
`default_nettype none
module interleaved_planar_to_chunky_unit import ipc_pkg::*; #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_PLANES = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic              cfg_index,
	input  wire logic [RW_W-1:0]   cfg_data,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [WORD_W-1:0] s_tdata,  // bitmap_word
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [31:0]            m_tdata,  // pixel_value, red, green, blue
	output logic                   m_tuser,  // last_of_burst
	output logic                   m_tlast   // end_of_row
);

	logic [MODE_W-1:0] plane_mode_q;
	logic [RW_W-1:0]   row_width_q;
	logic              q_push;
	logic              q_pop;
	job_t              push_job;
	job_t              head_job;
	q_status_t         q_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_mode_q <= '0;
			row_width_q  <= RW_W'(320);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PLANE_MODE: plane_mode_q <= cfg_data[MODE_W-1:0];
				REG_ROW_WIDTH:  row_width_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	ipc_front #(.MAX_PLANES(MAX_PLANES)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.plane_mode (plane_mode_q),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.q_stat     (q_stat),
		.q_push     (q_push),
		.q_job      (push_job)
	);

	ipc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.pop      (q_pop),
		.head_job (head_job),
		.stat     (q_stat)
	);

	ipc_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.row_width (row_width_q),
		.head_job  (head_job),
		.q_stat    (q_stat),
		.q_pop     (q_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule
`default_nettype wire

/* test/interleaved_planar_to_chunky_unit_tb.sv */
// self-checking testbench of the interleaved bitplane to chunky pixel converter
`timescale 1ns / 100ps
module interleaved_planar_to_chunky_unit_tb;
	import ipc_pkg::*;

	localparam int MAX_ROW      = 4096;
	localparam int SETTLE       = 8;
	localparam int LIMIT        = 300000;
	localparam int RANDOM_ITEMS = 400;

	localparam logic [MODE_W-1:0] MODE_PLANE1    = 3'd0;
	localparam logic [MODE_W-1:0] MODE_PLANE2    = 3'd1;
	localparam logic [MODE_W-1:0] MODE_PLANE4    = 3'd2;
	localparam logic [MODE_W-1:0] MODE_SPARE_LO  = 3'd5;
	localparam logic [MODE_W-1:0] MODE_SPARE_HI  = 3'd7;

	typedef struct packed {
		logic [PIX_W-1:0] index;
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
		logic             burst_end;
		logic             row_end;
	} pixel_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic              cfg_index = 1'b0;
	logic [RW_W-1:0]   cfg_data = '0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [WORD_W-1:0] s_tdata = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [31:0]       m_tdata;
	logic              m_tuser;
	logic              m_tlast;

	bit          steady = 1'b0;
	int          err_count = 0;
	int          random_words = 0;
	int unsigned cycle_count = 0;

	// converter state as predicted
	logic [MODE_W-1:0] mode_q = MODE_PLANE1;
	logic [RW_W-1:0]   width_q = 13'd320;
	logic [WORD_W-1:0] plane_store [0:6];
	int                plane_cnt = 0;
	int                col_cnt = 0;
	pixel_t            pending_pixels [$];

	interleaved_planar_to_chunky_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(negedge clk) begin
		m_tready <= steady || ($urandom_range(0, 99) >= 24);
	end

	function automatic int row_len();
		int len;
		len = ((int'(width_q) + 15) >> 4) << 4;
		if (len == 0)
			len = GROUP_PIX;
		if (len > MAX_ROW)
			len = MAX_ROW;
		return len;
	endfunction

	function automatic void push_pixel(input logic [PIX_W-1:0] index, input logic [PIX_W-1:0] r,
			input logic [PIX_W-1:0] g, input logic [PIX_W-1:0] b, input logic burst_end);
		pixel_t p;
		p.index = index;
		p.red = r;
		p.green = g;
		p.blue = b;
		p.burst_end = burst_end;
		p.row_end = (col_cnt + 1 >= row_len());
		col_cnt = p.row_end ? 0 : col_cnt + 1;
		pending_pixels.push_back(p);
	endfunction

	function automatic void predict_pixels(input logic [WORD_W-1:0] w);
		int n_planes;
		logic [PIX_W-1:0] index;
		if (mode_q == MODE_RGB565) begin
			plane_cnt = 0;
			push_pixel('0, {w[15:11], 3'b000}, {w[10:5], 2'b00}, {w[4:0], 3'b000}, 1'b1);
		end else if (mode_q < MODE_RGB565) begin
			n_planes = 1 << mode_q;
			if (plane_cnt + 1 < n_planes) begin
				plane_store[plane_cnt] = w;
				plane_cnt++;
			end else begin
				plane_cnt = 0;
				for (int b = 15; b >= 0; b--) begin
					index = '0;
					for (int k = 0; k < n_planes - 1; k++)
						index[k] = plane_store[k][b];
					index[n_planes-1] = w[b];
					push_pixel(index, '0, '0, '0, b == 0);
				end
			end
		end
	endfunction

	task automatic check_field(input string name, input logic [PIX_W-1:0] exp_v,
			input logic [PIX_W-1:0] got_v);
		if (got_v !== exp_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
			err_count++;
		end
	endtask

	always @(posedge clk) begin
		pixel_t exp_p;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_pixels.size() == 0) begin
				$display("%0t: unexpected pixel, expected none, actual %h %b %b", $time,
					m_tdata, m_tuser, m_tlast);
				err_count++;
			end else begin
				exp_p = pending_pixels.pop_front();
				check_field("pixel_value", exp_p.index, m_tdata[7:0]);
				check_field("red", exp_p.red, m_tdata[15:8]);
				check_field("green", exp_p.green, m_tdata[23:16]);
				check_field("blue", exp_p.blue, m_tdata[31:24]);
				check_field("last_of_burst", 8'(exp_p.burst_end), 8'(m_tuser));
				check_field("end_of_row", 8'(exp_p.row_end), 8'(m_tlast));
			end
		end
	end

	task automatic send_word(input logic [WORD_W-1:0] w);
		@(negedge clk);
		while (!steady && $urandom_range(0, 99) < 24) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= w;
		do @(posedge clk); while (!s_tready);
		predict_pixels(w);
	endtask

	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [RW_W-1:0] val);
		@(negedge clk);
		s_tvalid <= 1'b0;
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_PLANE_MODE)
			mode_q = val[MODE_W-1:0];
		else
			width_q = val;
	endtask

	function automatic logic [WORD_W-1:0] rand_word();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return WORD_W'($urandom);
		endcase
	endfunction

	task automatic test_reset_defaults();
		send_word(16'h0000);
		send_word(16'hffff);
		drain();
	endtask

	task automatic test_plane8_group();
		write_reg(REG_PLANE_MODE, 13'(MODE_PLANE8));
		write_reg(REG_ROW_WIDTH, 13'd16);
		send_word(16'h8000);
		send_word(16'h0001);
		send_word(16'hffff);
		send_word(16'h0000);
		send_word(16'h5555);
		send_word(16'haaaa);
		send_word(16'h1234);
		send_word(16'hfedc);
		drain();
	endtask

	task automatic test_rgb565();
		write_reg(REG_PLANE_MODE, 13'(MODE_RGB565));
		send_word(16'hffff);
		send_word(16'hf800);
		send_word(16'h07e0);
		send_word(16'h001f);
		drain();
	endtask

	task automatic test_spare_modes();
		// upper data bits are masked off by the mode register
		write_reg(REG_PLANE_MODE, {10'h3ff, MODE_SPARE_LO});
		send_word(16'hffff);
		send_word(16'h0000);
		write_reg(REG_PLANE_MODE, 13'(MODE_SPARE_HI));
		send_word(16'h1234);
		drain();
	endtask

	task automatic test_width_edges();
		write_reg(REG_PLANE_MODE, 13'(MODE_PLANE1));
		write_reg(REG_ROW_WIDTH, 13'd0);
		send_word(16'hc3a5);
		drain();
		write_reg(REG_ROW_WIDTH, 13'h1fff);
		send_word(16'h5a3c);
		drain();
		write_reg(REG_ROW_WIDTH, 13'(MAX_ROW));
		send_word(16'h0f0f);
		send_word(16'hf0f0);
		drain();
		// shrink below the current column, the next pixel ends the row
		write_reg(REG_ROW_WIDTH, 13'd16);
		send_word(16'h8001);
		drain();
	endtask

	task automatic test_mode_switch_mid_group();
		write_reg(REG_PLANE_MODE, 13'(MODE_PLANE8));
		send_word(16'h9bdf);
		send_word(16'h2468);
		send_word(16'h1357);
		drain();
		write_reg(REG_PLANE_MODE, 13'(MODE_PLANE2));
		send_word(16'hace1);
		drain();
		write_reg(REG_PLANE_MODE, 13'(MODE_PLANE4));
		send_word(16'h7777);
		drain();
		// a 16-bit word drops the partial group
		write_reg(REG_PLANE_MODE, 13'(MODE_RGB565));
		send_word(16'h4208);
		drain();
		write_reg(REG_PLANE_MODE, 13'(MODE_PLANE2));
		send_word(16'hff00);
		send_word(16'h0ff0);
		drain();
	endtask

	task automatic test_back_to_back();
		write_reg(REG_PLANE_MODE, 13'(MODE_PLANE4));
		write_reg(REG_ROW_WIDTH, 13'd48);
		steady = 1'b1;
		repeat (40) begin
			send_word(rand_word());
			random_words++;
		end
		drain();
		steady = 1'b0;
	endtask

	task automatic test_random_phases();
		int n_words;
		int n_planes;
		logic [MODE_W-1:0] m;
		logic [RW_W-1:0] w;
		while (random_words < RANDOM_ITEMS) begin
			drain();
			if ($urandom_range(0, 19) == 0)
				m = MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
			else
				m = MODE_W'($urandom_range(MODE_PLANE1, MODE_RGB565));
			case ($urandom_range(0, 11))
				0: w = '0;
				1: w = RW_W'($urandom_range(MAX_ROW + 1, 8191));
				2: w = RW_W'($urandom_range(1, MAX_ROW));
				default: w = RW_W'($urandom_range(1, 64));
			endcase
			if ($urandom_range(0, 3) != 0)
				write_reg(REG_PLANE_MODE, {RW_W'($urandom) & ~RW_W'(7) | 13'(m)});
			if ($urandom_range(0, 3) != 0)
				write_reg(REG_ROW_WIDTH, w);
			if (mode_q > MODE_RGB565) begin
				repeat ($urandom_range(1, 3))
					send_word(rand_word());
			end else begin
				if (mode_q == MODE_RGB565) begin
					n_words = $urandom_range(1, 24);
				end else begin
					n_planes = 1 << mode_q;
					n_words = n_planes * $urandom_range(1, 3);
					// now and then add extra words, which can leave a partial group for the next phase
					if ($urandom_range(0, 3) == 0)
						n_words += $urandom_range(1, n_planes);
				end
				repeat (n_words) begin
					send_word(rand_word());
					random_words++;
				end
			end
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_plane8_group();
		test_rgb565();
		test_spare_modes();
		test_width_edges();
		test_mode_switch_mid_group();
		test_back_to_back();
		test_random_phases();
		drain();
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* filelist.f */
design/ipc_pkg.sv
design/ipc_front.sv
design/ipc_queue.sv
design/ipc_back.sv
design/interleaved_planar_to_chunky_unit.sv
test/interleaved_planar_to_chunky_unit_tb.sv
